/* rtl/core/dvt_pkg.sv */
// Shared types, codes and default values for the detection vote table.
`default_nettype none

package dvt_pkg;

	localparam int DEF_TABLE_DEPTH      = 16;
	localparam int DEF_RADIUS_FRAC_BITS = 4;
	localparam int DEF_COORD_BITS       = 12;

	localparam int RADIUS_BITS    = 11;
	localparam int VOTE_BITS      = 8;
	localparam int CFG_INDEX_BITS = 3;

	localparam int MIN_RADIUS_RESET   = 80;
	localparam int MAX_RADIUS_RESET   = 480;
	localparam int FRAME_WIDTH_RESET  = 1280;
	localparam int FRAME_HEIGHT_RESET = 720;
	localparam int VOTE_LIMIT_RESET   = 7;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_MIN_RADIUS   = 3'd0,
		REG_MAX_RADIUS   = 3'd1,
		REG_FRAME_WIDTH  = 3'd2,
		REG_FRAME_HEIGHT = 3'd3,
		REG_VOTE_LIMIT   = 3'd4
	} reg_index_t;

	typedef enum logic [2:0] {
		STAT_REJECTED = 3'd0,
		STAT_VOTED    = 3'd1,
		STAT_ADDED    = 3'd2,
		STAT_FULL     = 3'd3,
		STAT_CLEARED  = 3'd4
	} status_t;

	typedef struct packed {
		logic load;
		logic scan_start;
		logic scan_read;
		logic update;
	} dvt_cmd_t;

	typedef struct packed {
		logic is_clear;
		logic table_empty;
		logic scan_last;
		logic out_free;
	} dvt_stat_t;

endpackage

`default_nettype wire

/* rtl/core/detection_vote_table_top.sv */
// Top level of the detection vote table: configuration registers, controller and datapath.
`default_nettype none

// An item goes from its accepting beat through the start, scan, drain and update states to
// its result beat: every detect item reads all valid entries through the single read port
// of the entry memory, one entry per cycle, to find the highest matching entry and to
// gather the confirmed flag; a clear item or an empty table skips scan and drain. The next
// item is accepted once the table update is done, even while the result beat still waits.
// Configuration writes take effect at once and belong in idle periods.
module detection_vote_table_top
	import dvt_pkg::*;
#(
	parameter int TABLE_DEPTH      = DEF_TABLE_DEPTH,
	parameter int RADIUS_FRAC_BITS = DEF_RADIUS_FRAC_BITS,
	parameter int COORD_BITS       = DEF_COORD_BITS,
	localparam int IDX_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
	localparam int CNT_W      = $clog2(TABLE_DEPTH + 1),
	localparam int CFG_DATA_W = (COORD_BITS > RADIUS_BITS) ? COORD_BITS : RADIUS_BITS
) (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      cfg_wr_en,
	input  wire [CFG_INDEX_BITS-1:0] cfg_index,
	input  wire [CFG_DATA_W-1:0]     cfg_data,
	input  wire                      in_valid,
	output logic                     in_ready,
	input  wire                      mode,
	input  wire [COORD_BITS-1:0]     center_x,
	input  wire [COORD_BITS-1:0]     center_y,
	input  wire [RADIUS_BITS-1:0]    circle_radius,
	output logic                     out_valid,
	input  wire                      out_ready,
	output logic [2:0]               status,
	output logic [IDX_W-1:0]         entry_index,
	output logic [VOTE_BITS-1:0]     entry_vote,
	output logic [CNT_W-1:0]         entry_count,
	output logic                     confirmed
);

	logic [RADIUS_BITS-1:0] min_radius_q;
	logic [RADIUS_BITS-1:0] max_radius_q;
	logic [COORD_BITS-1:0]  frame_width_q;
	logic [COORD_BITS-1:0]  frame_height_q;
	logic [VOTE_BITS-1:0]   vote_limit_q;

	dvt_cmd_t  cmd;
	dvt_stat_t stat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_radius_q   <= RADIUS_BITS'(MIN_RADIUS_RESET);
			max_radius_q   <= RADIUS_BITS'(MAX_RADIUS_RESET);
			frame_width_q  <= COORD_BITS'(FRAME_WIDTH_RESET);
			frame_height_q <= COORD_BITS'(FRAME_HEIGHT_RESET);
			vote_limit_q   <= VOTE_BITS'(VOTE_LIMIT_RESET);
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_MIN_RADIUS:   min_radius_q   <= cfg_data[RADIUS_BITS-1:0];
				REG_MAX_RADIUS:   max_radius_q   <= cfg_data[RADIUS_BITS-1:0];
				REG_FRAME_WIDTH:  frame_width_q  <= cfg_data[COORD_BITS-1:0];
				REG_FRAME_HEIGHT: frame_height_q <= cfg_data[COORD_BITS-1:0];
				REG_VOTE_LIMIT:   vote_limit_q   <= cfg_data[VOTE_BITS-1:0];
				default: ;
			endcase
		end
	end

	dvt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	dvt_datapath #(
		.TABLE_DEPTH      (TABLE_DEPTH),
		.RADIUS_FRAC_BITS (RADIUS_FRAC_BITS),
		.COORD_BITS       (COORD_BITS)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.in_mode       (mode),
		.in_x          (center_x),
		.in_y          (center_y),
		.in_radius     (circle_radius),
		.min_radius    (min_radius_q),
		.max_radius    (max_radius_q),
		.frame_width   (frame_width_q),
		.frame_height  (frame_height_q),
		.vote_limit    (vote_limit_q),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.out_status    (status),
		.out_index     (entry_index),
		.out_vote      (entry_vote),
		.out_count     (entry_count),
		.out_confirmed (confirmed)
	);

	// An accepted beat keeps the input closed until its table update is done.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted during item processing");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> entry_count <= CNT_W'(TABLE_DEPTH))
		else $error("entry count beyond table depth");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == STAT_CLEARED |-> entry_count == '0 && !confirmed)
		else $error("clear result reports a non-empty table");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == STAT_REJECTED || status == STAT_FULL)
		|-> entry_index == '0 && entry_vote == '0)
		else $error("dropped item reports an entry");

endmodule

`default_nettype wire

/* rtl/core/dvt_ctrl.sv */
// Sequencing state machine for the detection vote table.
`default_nettype none

module dvt_ctrl
	import dvt_pkg::*;
(
	input  wire        clk,
	input  wire        arst_n,
	input  wire        in_valid,
	output logic       in_ready,
	input  dvt_stat_t  stat,
	output dvt_cmd_t   cmd
);

	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_START  = 5'b00010,
		S_SCAN   = 5'b00100,
		S_DRAIN  = 5'b01000,
		S_UPDATE = 5'b10000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_START;
				end
			end
			S_START: begin
				if (stat.is_clear || stat.table_empty) begin
					state_d = S_UPDATE;
				end else begin
					cmd.scan_start = 1'b1;
					state_d        = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.scan_read = 1'b1;
				if (stat.scan_last) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				state_d = S_UPDATE;
			end
			S_UPDATE: begin
				if (stat.out_free) begin
					cmd.update = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

/* rtl/core/dvt_datapath.sv */
// Entry memory, match scan, table update and result register of the vote table.
`default_nettype none

module dvt_datapath
	import dvt_pkg::*;
#(
	parameter int TABLE_DEPTH      = DEF_TABLE_DEPTH,
	parameter int RADIUS_FRAC_BITS = DEF_RADIUS_FRAC_BITS,
	parameter int COORD_BITS       = DEF_COORD_BITS,
	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1)
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  dvt_cmd_t               cmd,
	output dvt_stat_t              stat,
	input  wire                    in_mode,
	input  wire [COORD_BITS-1:0]   in_x,
	input  wire [COORD_BITS-1:0]   in_y,
	input  wire [RADIUS_BITS-1:0]  in_radius,
	input  wire [RADIUS_BITS-1:0]  min_radius,
	input  wire [RADIUS_BITS-1:0]  max_radius,
	input  wire [COORD_BITS-1:0]   frame_width,
	input  wire [COORD_BITS-1:0]   frame_height,
	input  wire [VOTE_BITS-1:0]    vote_limit,
	output logic                   out_valid,
	input  wire                    out_ready,
	output logic [2:0]             out_status,
	output logic [IDX_W-1:0]       out_index,
	output logic [VOTE_BITS-1:0]   out_vote,
	output logic [CNT_W-1:0]       out_count,
	output logic                   out_confirmed
);

	localparam int FX_W   = COORD_BITS + RADIUS_FRAC_BITS;
	localparam int WIDE_W = ((FX_W > RADIUS_BITS) ? FX_W : RADIUS_BITS) + 1;

	typedef struct packed {
		logic [COORD_BITS-1:0]  x;
		logic [COORD_BITS-1:0]  y;
		logic [RADIUS_BITS-1:0] r;
		logic [VOTE_BITS-1:0]   vote;
	} entry_t;

	entry_t mem [TABLE_DEPTH];
	entry_t rd_q;
	entry_t hit_entry_q;
	entry_t wr_data;
	logic [IDX_W-1:0] wr_addr;
	logic             wr_en;

	logic                   mode_q;
	logic [COORD_BITS-1:0]  cx_q;
	logic [COORD_BITS-1:0]  cy_q;
	logic [RADIUS_BITS-1:0] r_q;

	logic [CNT_W-1:0] fill_q;
	logic [CNT_W-1:0] fill_m1;
	logic [IDX_W-1:0] idx_q;
	logic [IDX_W-1:0] idx_s1;
	logic [IDX_W-1:0] hit_idx_q;
	logic             valid_s1;
	logic             hit_q;
	logic             over_q;
	logic             out_valid_q;

	status_t        status_q;
	logic [IDX_W-1:0]     index_q;
	logic [VOTE_BITS-1:0] vote_q;
	logic [CNT_W-1:0]     count_q;
	logic                 confirmed_q;

	logic [WIDE_W-1:0] px, py, rw, fw, fh, ex, ey, er;
	logic in_square, item_ok, full, voted, added;
	logic [VOTE_BITS-1:0] new_vote;
	status_t        status_d;
	logic [IDX_W-1:0]     index_d;
	logic [VOTE_BITS-1:0] vote_d;
	logic [CNT_W-1:0]     fill_d;
	logic                 confirmed_d;

	assign px = WIDE_W'(cx_q) << RADIUS_FRAC_BITS;
	assign py = WIDE_W'(cy_q) << RADIUS_FRAC_BITS;
	assign rw = WIDE_W'(r_q);
	assign fw = WIDE_W'(frame_width) << RADIUS_FRAC_BITS;
	assign fh = WIDE_W'(frame_height) << RADIUS_FRAC_BITS;
	assign ex = WIDE_W'(rd_q.x) << RADIUS_FRAC_BITS;
	assign ey = WIDE_W'(rd_q.y) << RADIUS_FRAC_BITS;
	assign er = WIDE_W'(rd_q.r);

	assign in_square = (ex < px + er) && (ex + er > px) && (ey < py + er) && (ey + er > py);

	assign item_ok = (r_q > min_radius) && (r_q < max_radius) &&
		(px > rw) && (px + rw < fw) && (py > rw) && (py + rw < fh);

	assign fill_m1  = fill_q - CNT_W'(1);
	assign full     = (fill_q == CNT_W'(TABLE_DEPTH));
	assign voted    = !mode_q && item_ok && hit_q;
	assign added    = !mode_q && item_ok && !hit_q && !full;
	assign new_vote = (hit_entry_q.vote == {VOTE_BITS{1'b1}}) ? hit_entry_q.vote :
		hit_entry_q.vote + VOTE_BITS'(1);

	always_comb begin
		if (mode_q) begin
			status_d = STAT_CLEARED;
		end else if (!item_ok) begin
			status_d = STAT_REJECTED;
		end else if (hit_q) begin
			status_d = STAT_VOTED;
		end else if (full) begin
			status_d = STAT_FULL;
		end else begin
			status_d = STAT_ADDED;
		end
		index_d     = voted ? hit_idx_q : (added ? fill_q[IDX_W-1:0] : '0);
		vote_d      = voted ? new_vote : '0;
		fill_d      = mode_q ? '0 : (added ? fill_q + CNT_W'(1) : fill_q);
		confirmed_d = !mode_q && (over_q || (voted && (new_vote > vote_limit)));
		wr_en       = cmd.update && (voted || added);
		wr_addr     = voted ? hit_idx_q : fill_q[IDX_W-1:0];
		if (voted) begin
			wr_data      = hit_entry_q;
			wr_data.vote = new_vote;
		end else begin
			wr_data.x    = cx_q;
			wr_data.y    = cy_q;
			wr_data.r    = r_q;
			wr_data.vote = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (cmd.scan_read) begin
			rd_q <= mem[idx_q];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q <= in_mode;
			cx_q   <= in_x;
			cy_q   <= in_y;
			r_q    <= in_radius;
		end
		if (cmd.scan_read) begin
			idx_s1 <= idx_q;
		end
		if (valid_s1 && in_square && !hit_q) begin
			hit_idx_q   <= idx_s1;
			hit_entry_q <= rd_q;
		end
		if (cmd.update) begin
			status_q    <= status_d;
			index_q     <= index_d;
			vote_q      <= vote_d;
			count_q     <= fill_d;
			confirmed_q <= confirmed_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			idx_q       <= '0;
			valid_s1    <= 1'b0;
			hit_q       <= 1'b0;
			over_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			valid_s1 <= cmd.scan_read;
			if (cmd.scan_start) begin
				idx_q <= fill_m1[IDX_W-1:0];
			end else if (cmd.scan_read) begin
				idx_q <= idx_q - IDX_W'(1);
			end
			if (cmd.load) begin
				hit_q  <= 1'b0;
				over_q <= 1'b0;
			end else if (valid_s1) begin
				if (in_square) begin
					hit_q <= 1'b1;
				end
				if (rd_q.vote > vote_limit) begin
					over_q <= 1'b1;
				end
			end
			if (cmd.update) begin
				fill_q      <= fill_d;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign stat.is_clear    = mode_q;
	assign stat.table_empty = (fill_q == '0);
	assign stat.scan_last   = (idx_q == '0);
	assign stat.out_free    = !out_valid_q || out_ready;

	assign out_valid     = out_valid_q;
	assign out_status    = status_q;
	assign out_index     = index_q;
	assign out_vote      = vote_q;
	assign out_count     = count_q;
	assign out_confirmed = confirmed_q;

endmodule

`default_nettype wire
